// ===== src/sorted_value_table_assert.svh =====
// Assertion macros for the sorted value table.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef SORTED_VALUE_TABLE_ASSERT_SVH
`define SORTED_VALUE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SVT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_value_table: implication check failed");
`define SVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_value_table: next-cycle check failed");
`define SVT_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("sorted_value_table: forbidden condition seen");
`else
`define SVT_ASSERT_IMPL(label, ante, cons)
`define SVT_ASSERT_NEXT(label, ante, cons)
`define SVT_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== src/svt_pkg.sv =====
// Shared types and constants for the sorted value table.
// No dependencies.
package svt_pkg;

  localparam int VAL_W            = 32;
  localparam int FUNC_W           = 2;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } svt_state_t;

  typedef struct packed {
    logic                    cmp;
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
  } svt_cmd_t;

endpackage

// ===== src/svt_cell.sv =====
// One cell of the sorted row: holds one entry and its compare flags.
// Depends on svt_pkg.
module svt_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  svt_pkg::svt_cmd_t               cmd,
  input  logic [CNT_W-1:0]                count,
  input  logic                            left_less,
  input  logic signed [svt_pkg::VAL_W-1:0] left_value,
  input  logic signed [svt_pkg::VAL_W-1:0] right_value,
  output logic                            less,
  output logic signed [svt_pkg::VAL_W-1:0] value,
  output logic                            hit
);
  import svt_pkg::*;

  logic                    valid;
  logic                    eq;
  logic                    bnd;
  logic signed [VAL_W-1:0] value_next;

  assign valid = count > CNT_W'(INDEX);
  // first cell not below the key
  assign bnd   = !less && left_less;
  assign hit   = bnd && eq;

  always_comb begin
    value_next = value;
    if (cmd.ins && !less) begin
      value_next = bnd ? cmd.value : left_value;
    end else if (cmd.rem && !less) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      less <= 1'b0;
      eq   <= 1'b0;
    end else if (cmd.cmp) begin
      less <= valid && (value < cmd.value);
      eq   <= valid && (value == cmd.value);
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== src/sorted_value_table.sv =====
// Sorted value table: up to CAPACITY signed words held in ascending order
// in a row of cells. Each command word is accepted when start is high and
// busy is low; in the compare state every cell compares against the value,
// in the apply state the row shifts right (insert) or left (remove), and in the
// cycle after that done is high for exactly one cycle with the result. The
// receiver cannot stall, so results must be taken on the done cycle.
// The block takes no new command while one is in its compare and apply
// states; a new one is accepted in the done cycle. Depends on svt_pkg,
// svt_cell and the assert header.
`include "sorted_value_table_assert.svh"

module sorted_value_table #(
  parameter int CAPACITY = svt_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [svt_pkg::FUNC_W-1:0]         func,
  input  logic signed [svt_pkg::VAL_W-1:0]   value,
  output logic                               done,
  output logic                               found,
  output logic                               rejected_full,
  output logic [$clog2(CAPACITY+1)-1:0]      entry_count
);
  import svt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  svt_state_t              state;
  svt_state_t              state_next;
  logic [FUNC_W-1:0]       op;
  logic signed [VAL_W-1:0] key;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  svt_cmd_t                cmd;
  logic                    full;
  logic                    found_any;
  logic                    accept;

  logic                    less_row  [CAPACITY];
  logic signed [VAL_W-1:0] value_row [CAPACITY];
  logic [CAPACITY-1:0]     hit_row;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                    left_less;
      logic signed [VAL_W-1:0] left_value;
      logic signed [VAL_W-1:0] right_value;
      if (gi == 0) begin : g_first
        assign left_less  = 1'b1;
        assign left_value = key;
      end else begin : g_inner
        assign left_less  = less_row[gi-1];
        assign left_value = value_row[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_value = key;
      end else begin : g_body
        assign right_value = value_row[gi+1];
      end
      svt_cell #(
        .INDEX (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .count       (count),
        .left_less   (left_less),
        .left_value  (left_value),
        .right_value (right_value),
        .less        (less_row[gi]),
        .value       (value_row[gi]),
        .hit         (hit_row[gi])
      );
    end
  endgenerate

  assign accept    = start && !busy;
  assign full      = count == CNT_W'(CAPACITY);
  assign found_any = |hit_row;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    cmd.cmp   = 1'b0;
    cmd.ins   = 1'b0;
    cmd.rem   = 1'b0;
    cmd.value = key;
    unique case (state)
      S_IDLE:  busy = 1'b0;
      S_CMP:   cmd.cmp = 1'b1;
      S_APPLY: begin
        cmd.ins = (op == FUNC_INSERT) && !full;
        cmd.rem = (op == FUNC_REMOVE) && found_any;
      end
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= func;
      key <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      done          <= 1'b0;
      found         <= 1'b0;
      rejected_full <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= state == S_APPLY;
      if (state == S_APPLY) begin
        found         <= ((op == FUNC_QUERY) || (op == FUNC_REMOVE)) && found_any;
        rejected_full <= (op == FUNC_INSERT) && full;
      end
    end
  end

  assign entry_count = count;

  `SVT_ASSERT_NEVER(a_count_range, count > CNT_W'(CAPACITY))
  `SVT_ASSERT_NEXT(a_done_after_apply, state == S_APPLY, done)
  `SVT_ASSERT_IMPL(a_reject_when_full, done && rejected_full, entry_count == CNT_W'(CAPACITY))
  `SVT_ASSERT_NEVER(a_found_xor_reject, done && found && rejected_full)
  `SVT_ASSERT_NEVER(a_shift_one_way, cmd.ins && cmd.rem)

endmodule

// ===== sim/tb_top.sv =====
// Testbench for sorted_value_table: drives insert, query and remove words
// and checks every result against a mirror of the sorted table.
// Depends on svt_pkg and the sorted_value_table RTL.
`timescale 1ns / 1ps

module tb_top;
  import svt_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int RANDOM_WORDS = 1700;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic             found;
    logic             rejected_full;
    logic [CNT_W-1:0] entry_count;
  } table_outcome_t;

  class table_tracker;
    logic signed [VAL_W-1:0] cells[CAP];
    int unsigned             fill;
    table_outcome_t          outcomes_due[$];
    int unsigned             mismatches, words_in, hits, drops, full_seen, empty_seen;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    function int unsigned pending();
      return outcomes_due.size();
    endfunction

    function logic signed [VAL_W-1:0] pick_stored();
      if (fill == 0)
        return $urandom;
      return cells[$urandom_range(0, fill - 1)];
    endfunction

    task take_command(logic [FUNC_W-1:0] f, logic signed [VAL_W-1:0] v);
      table_outcome_t o;
      int unsigned    pos;
      o = '0;
      words_in++;
      if (f == FUNC_INSERT) begin
        if (fill >= CAP) begin
          o.rejected_full = 1'b1;
          drops++;
        end else begin
          pos = 0;
          while (pos < fill && cells[pos] < v)
            pos++;
          for (int i = fill; i > pos; i--)
            cells[i] = cells[i - 1];
          cells[pos] = v;
          fill++;
          if (fill == CAP)
            full_seen++;
        end
      end else if (f == FUNC_QUERY || f == FUNC_REMOVE) begin
        pos = 0;
        while (pos < fill && cells[pos] != v)
          pos++;
        if (pos < fill) begin
          o.found = 1'b1;
          hits++;
          if (f == FUNC_REMOVE) begin
            for (int i = pos; i + 1 < fill; i++)
              cells[i] = cells[i + 1];
            fill--;
            if (fill == 0)
              empty_seen++;
          end
        end
      end
      o.entry_count = fill[CNT_W-1:0];
      outcomes_due.push_back(o);
    endtask

    task check_outcome(logic fnd, logic rej, logic [CNT_W-1:0] cnt);
      table_outcome_t e;
      if (outcomes_due.size() == 0) begin
        report($sformatf("unexpected result found=%0d rejected_full=%0d entry_count=%0d",
                         fnd, rej, cnt));
        return;
      end
      e = outcomes_due.pop_front();
      if (fnd !== e.found)
        report($sformatf("found %0d, expected %0d", fnd, e.found));
      if (rej !== e.rejected_full)
        report($sformatf("rejected_full %0d, expected %0d", rej, e.rejected_full));
      if (cnt !== e.entry_count)
        report($sformatf("entry_count %0d, expected %0d", cnt, e.entry_count));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [FUNC_W-1:0]       func = FUNC_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    busy, done, found, rejected_full;
  logic [CNT_W-1:0]        entry_count;

  table_tracker sb = new();

  always #1 clk = ~clk;

  sorted_value_table #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .value(value),
    .done(done), .found(found), .rejected_full(rejected_full), .entry_count(entry_count)
  );

  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.take_command(func, value);
    if (!rst && done)
      sb.check_outcome(found, rejected_full, entry_count);
  end

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v);
    start <= 1'b1;
    func  <= f;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_table_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    #400000;
    $display("sorted_value_table test failed");
    $finish;
  end

  initial begin
    int unsigned             sent, burst, gap, r;
    bit                      filling;
    logic [FUNC_W-1:0]       f;
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] pool[8];

    pool = '{32'sh8000_0000, 32'sh8000_0001, -32'sd1, 32'sd0, 32'sd1,
             32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sd42};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, misses, unused code, full table
    send_word(FUNC_QUERY, 32'sd0);
    send_word(FUNC_REMOVE, 32'sd0);
    send_word(FUNC_INSERT, 32'sh8000_0000);
    send_word(FUNC_INSERT, 32'sh7FFF_FFFF);
    send_word(FUNC_INSERT, 32'sd0);
    send_word(FUNC_INSERT, -32'sd1);
    send_word(FUNC_INSERT, 32'sd0);
    send_word(FUNC_QUERY, 32'sh8000_0000);
    send_word(FUNC_QUERY, 32'sd7);
    send_word(FUNC_UNUSED, 32'sd0);
    send_word(FUNC_REMOVE, 32'sd0);
    send_word(FUNC_REMOVE, 32'sd12345);
    send_word(FUNC_QUERY, 32'sd0);
    for (int i = 0; i < CAP - 4; i++)
      send_word(FUNC_INSERT, i * 3 - 20);
    send_word(FUNC_INSERT, 32'sd5);
    drain_table_results();

    sent = 0;
    filling = 1'b0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        if (sb.fill == 0)
          filling = 1'b1;
        else if (sb.fill >= CAP && $urandom_range(0, 3) == 0)
          filling = 1'b0;
        else if ($urandom_range(0, 59) == 0)
          filling = !filling;

        r = $urandom_range(0, 99);
        if (r < 3)
          f = FUNC_UNUSED;
        else if (r < (filling ? 63 : 28))
          f = FUNC_INSERT;
        else if (r < (filling ? 80 : 48))
          f = FUNC_QUERY;
        else
          f = FUNC_REMOVE;

        r = $urandom_range(0, 9);
        if (r < 5)
          v = pool[$urandom_range(0, 7)];
        else if (r < 8)
          v = sb.pick_stored();
        else
          v = $urandom;

        send_word(f, v);
        if (f != FUNC_UNUSED)
          sent++;
        if (sent == RANDOM_WORDS / 2)
          drain_table_results();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    drain_table_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d words: %0d query/remove hits, %0d inserts dropped on a full table,",
             sb.words_in, sb.hits, sb.drops);
    $display("table filled %0d times and emptied by remove %0d times.",
             sb.full_seen, sb.empty_seen);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("sorted_value_table test passed");
    else
      $display("sorted_value_table test failed");
    $finish;
  end

endmodule
